### sv/afk_pkg.sv
package afk_pkg;

  // Geometry of the datapath.
  localparam int NLANE   = 4;
  localparam int NSTEP   = 5;
  localparam int PIPE_LAT = 24;

  // Fixed-point constants.
  localparam logic [23:0] PHASE_MUL = 24'd10680707;
  localparam logic [31:0] PI_Q30    = 32'd3373259426;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [29:0] HALF_Q30  = 30'h2000_0000;

  // Horner divisors and their reciprocals, floor(2^32 / d).
  localparam logic [6:0] SIN_DIV [NSTEP] = '{7'd72, 7'd42, 7'd20, 7'd6, 7'd1};
  localparam logic [6:0] COS_DIV [NSTEP] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
  localparam logic [32:0] SIN_RCP [NSTEP] = '{
    33'((64'd1 << 32) / 64'd72), 33'((64'd1 << 32) / 64'd42),
    33'((64'd1 << 32) / 64'd20), 33'((64'd1 << 32) / 64'd6),
    33'(64'd1 << 32)};
  localparam logic [32:0] COS_RCP [NSTEP] = '{
    33'((64'd1 << 32) / 64'd90), 33'((64'd1 << 32) / 64'd56),
    33'((64'd1 << 32) / 64'd30), 33'((64'd1 << 32) / 64'd12),
    33'((64'd1 << 32) / 64'd2)};

  // Configuration register indexes.
  typedef enum logic [3:0] {
    REG_BASE_OFFSET = 4'd0,
    REG_UPPER_LINK  = 4'd1,
    REG_FORE_LINK   = 4'd2,
    REG_WRIST_LINK  = 4'd3
  } reg_idx_t;

  // Per-lane angle context that travels beside the Horner chains.
  typedef struct packed {
    logic [1:0]  quad;
    logic        swap;
    logic [29:0] t;
    logic [29:0] t2;
  } ang_t;

  // Correct a reciprocal quotient estimate that may be one too small.
  function automatic logic [30:0] div_fix(logic [30:0] v, logic [63:0] e, logic [6:0] d);
    logic [30:0] qe;
    logic [37:0] prod;
    logic [37:0] rem;
    qe   = e[62:32];
    prod = 38'(qe) * 38'(d);
    rem  = 38'(v) - prod;
    return (rem >= 38'(d)) ? qe + 31'd1 : qe;
  endfunction

  // Round half up by a right shift, then saturate to 18 bits.
  function automatic logic signed [17:0] rnd_sat(logic signed [63:0] v, int sh);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    if (r > 64'sd131071) return 18'sd131071;
    if (r < -64'sd131072) return -18'sd131072;
    return r[17:0];
  endfunction

endpackage

### sv/arm_forward_kinematics_4dof.sv
// Throughput: one joint vector per cycle; busy is low whenever reset is low.
// The pipeline is four angle lanes of polynomial sine/cosine followed by
// the link multiply and sum stages; each multiply has a register after it.
// Reset (rst, synchronous) clears all valid bits and loads the default links.
// Results cannot be stalled: done marks each result for one cycle.
module arm_forward_kinematics_4dof (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [17:0] base_angle,
  input  logic signed [17:0] shoulder_angle,
  input  logic signed [17:0] elbow_angle,
  input  logic signed [17:0] wrist_angle,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic signed [17:0] pos_x,
  output logic signed [17:0] pos_y,
  output logic signed [17:0] pos_z
);

  localparam int NL = afk_pkg::NLANE;
  localparam int NS = afk_pkg::NSTEP;

  logic [15:0] base_offset, upper_link, fore_link, wrist_link;
  logic        accept;

  // Stage valid bits.
  logic vld1, vld2, vld3;
  logic vld_c [0:NS];
  logic vld_m [0:NS-1];
  logic vld_r [0:NS-1];
  logic vld20, vld21, vld22, vld23;

  // Angle front end.
  logic signed [19:0] sum_a [NL];
  logic signed [44:0] ph_prod [NL];
  logic [31:0]        phase [NL];
  logic [29:0]        g3 [NL];
  logic               sw3 [NL];
  logic               sw_d [NL];
  logic [1:0]         quad3 [NL];
  logic [29:0]        t3 [NL];

  // Horner chains.
  afk_pkg::ang_t ctx_c [0:NS][NL];
  afk_pkg::ang_t ctx_m [0:NS-1][NL];
  afk_pkg::ang_t ctx_r [0:NS-1][NL];
  logic [30:0]   xs_c [0:NS][NL];
  logic [30:0]   xc_c [0:NS][NL];
  logic [60:0]   pm_s [0:NS-1][NL];
  logic [60:0]   pm_c [0:NS-1][NL];
  logic [30:0]   vs [0:NS-1][NL];
  logic [30:0]   vc [0:NS-1][NL];
  logic [63:0]   es [0:NS-1][NL];
  logic [63:0]   ec [0:NS-1][NL];

  // Back end.
  logic signed [31:0] sn [NL];
  logic signed [31:0] cs [NL];
  logic signed [48:0] ls [3];
  logic signed [48:0] lc [3];
  logic signed [31:0] s1_21, c1_21, s1_22, c1_22;
  logic signed [33:0] r14;
  logic signed [50:0] zsum, zsum23;
  logic signed [48:0] ox, oc;
  logic signed [65:0] cr, sr;
  logic signed [63:0] x64, y64;

  assign busy      = rst;
  assign cfg_ready = ~rst;
  assign accept    = start & ~busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_offset <= 16'd8520;
      upper_link  <= 16'd29229;
      fore_link   <= 16'd23658;
      wrist_link  <= 16'd9339;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        afk_pkg::REG_BASE_OFFSET: base_offset <= cfg_data;
        afk_pkg::REG_UPPER_LINK:  upper_link  <= cfg_data;
        afk_pkg::REG_FORE_LINK:   fore_link   <= cfg_data;
        afk_pkg::REG_WRIST_LINK:  wrist_link  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front-end valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1     <= 1'b0;
      vld2     <= 1'b0;
      vld3     <= 1'b0;
      vld_c[0] <= 1'b0;
    end else begin
      vld1     <= accept;
      vld2     <= vld1;
      vld3     <= vld2;
      vld_c[0] <= vld3;
    end
  end

  // Stage 1: the base angle and the three pitch sums.
  always_ff @(posedge clk) begin
    sum_a[0] <= 20'(base_angle);
    sum_a[1] <= 20'(shoulder_angle);
    sum_a[2] <= 20'(shoulder_angle) + 20'(elbow_angle);
    sum_a[3] <= 20'(shoulder_angle) + 20'(elbow_angle) + 20'(wrist_angle);
  end

  // Stages 2 to 4 for each lane: phase, angle in the octant, its square.
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      ph_prod[l] = 45'(sum_a[l]) * 45'(signed'({1'b0, afk_pkg::PHASE_MUL}));
      sw3[l]     = phase[l][29:0] > afk_pkg::HALF_Q30;
      g3[l]      = sw3[l] ? 30'(afk_pkg::ONE_Q30 - 31'(phase[l][29:0])) : phase[l][29:0];
    end
  end

  // The swap flag rides beside the quadrant through stage 3.
  always_ff @(posedge clk) begin
    for (int l = 0; l < NL; l++) begin
      logic [61:0] tp;
      logic [59:0] sq;
      phase[l] <= ph_prod[l][39:8];
      tp        = 62'(g3[l]) * 62'(afk_pkg::PI_Q30);
      t3[l]    <= tp[60:31];
      quad3[l] <= phase[l][31:30];
      sw_d[l]  <= sw3[l];
      sq        = 60'(t3[l]) * 60'(t3[l]);
      ctx_c[0][l] <= '{quad: quad3[l], swap: sw_d[l], t: t3[l], t2: sq[59:30]};
      xs_c[0][l]  <= afk_pkg::ONE_Q30;
      xc_c[0][l]  <= afk_pkg::ONE_Q30;
    end
  end

  // Horner steps: multiply, reciprocal estimate, correction.
  for (genvar k = 0; k < NS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_m[k]   <= 1'b0;
        vld_r[k]   <= 1'b0;
        vld_c[k+1] <= 1'b0;
      end else begin
        vld_m[k]   <= vld_c[k];
        vld_r[k]   <= vld_m[k];
        vld_c[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < NL; l++) begin
        logic [30:0] qs;
        logic [30:0] qc;
        // Multiply stage: the last sine step multiplies by t.
        pm_s[k][l]  <= 61'((k == NS - 1) ? ctx_c[k][l].t : ctx_c[k][l].t2) * 61'(xs_c[k][l]);
        pm_c[k][l]  <= 61'(ctx_c[k][l].t2) * 61'(xc_c[k][l]);
        ctx_m[k][l] <= ctx_c[k][l];
        // Reciprocal stage.
        vs[k][l]    <= pm_s[k][l][60:30];
        vc[k][l]    <= pm_c[k][l][60:30];
        es[k][l]    <= 64'(pm_s[k][l][60:30]) * 64'(afk_pkg::SIN_RCP[k]);
        ec[k][l]    <= 64'(pm_c[k][l][60:30]) * 64'(afk_pkg::COS_RCP[k]);
        ctx_r[k][l] <= ctx_m[k][l];
        // Correction stage.
        qs = afk_pkg::div_fix(vs[k][l], es[k][l], afk_pkg::SIN_DIV[k]);
        qc = afk_pkg::div_fix(vc[k][l], ec[k][l], afk_pkg::COS_DIV[k]);
        xs_c[k+1][l]  <= (k == NS - 1) ? qs : afk_pkg::ONE_Q30 - qs;
        xc_c[k+1][l]  <= afk_pkg::ONE_Q30 - qc;
        ctx_c[k+1][l] <= ctx_r[k][l];
      end
    end
  end

  // Back-end valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld20 <= 1'b0;
      vld21 <= 1'b0;
      vld22 <= 1'b0;
      vld23 <= 1'b0;
      done  <= 1'b0;
    end else begin
      vld20 <= vld_c[NS];
      vld21 <= vld20;
      vld22 <= vld21;
      vld23 <= vld22;
      done  <= vld23;
    end
  end

  // Stage 20: undo the octant swap and apply the quadrant signs.
  always_ff @(posedge clk) begin
    for (int l = 0; l < NL; l++) begin
      logic signed [31:0] ps;
      logic signed [31:0] pc;
      ps = ctx_c[NS][l].swap ? 32'(xc_c[NS][l]) : 32'(xs_c[NS][l]);
      pc = ctx_c[NS][l].swap ? 32'(xs_c[NS][l]) : 32'(xc_c[NS][l]);
      case (ctx_c[NS][l].quad)
        2'd0:    begin sn[l] <= ps;  cs[l] <= pc;  end
        2'd1:    begin sn[l] <= pc;  cs[l] <= -ps; end
        2'd2:    begin sn[l] <= -ps; cs[l] <= -pc; end
        default: begin sn[l] <= -pc; cs[l] <= ps;  end
      endcase
    end
  end

  // Stage 21: link lengths times the pitch sines and cosines.
  always_ff @(posedge clk) begin
    ls[0] <= 49'(signed'({1'b0, upper_link})) * 49'(sn[1]);
    ls[1] <= 49'(signed'({1'b0, fore_link}))  * 49'(sn[2]);
    ls[2] <= 49'(signed'({1'b0, wrist_link})) * 49'(sn[3]);
    lc[0] <= 49'(signed'({1'b0, upper_link})) * 49'(cs[1]);
    lc[1] <= 49'(signed'({1'b0, fore_link}))  * 49'(cs[2]);
    lc[2] <= 49'(signed'({1'b0, wrist_link})) * 49'(cs[3]);
    s1_21 <= sn[0];
    c1_21 <= cs[0];
  end

  // Stage 22: reach and height sums; reach is cut to 14 fraction bits.
  always_ff @(posedge clk) begin
    logic signed [50:0] rsum;
    rsum   = 51'(ls[0]) + 51'(ls[1]) + 51'(ls[2]);
    r14   <= 34'(rsum >>> 16);
    zsum  <= 51'(lc[0]) + 51'(lc[1]) + 51'(lc[2]);
    s1_22 <= s1_21;
    c1_22 <= c1_21;
  end

  // Stage 23: base rotation products.
  always_ff @(posedge clk) begin
    ox     <= 49'(signed'({1'b0, base_offset})) * 49'(s1_22);
    oc     <= 49'(signed'({1'b0, base_offset})) * 49'(c1_22);
    cr     <= 66'(c1_22) * 66'(r14);
    sr     <= 66'(s1_22) * 66'(r14);
    zsum23 <= zsum;
  end

  // Stage 24: combine, round and saturate.
  always_comb begin
    x64 = (64'(ox) <<< 14) - 64'(cr);
    y64 = -(64'(oc) <<< 14) - 64'(sr);
  end

  always_ff @(posedge clk) begin
    pos_x <= afk_pkg::rnd_sat(x64, 44);
    pos_y <= afk_pkg::rnd_sat(y64, 44);
    pos_z <= afk_pkg::rnd_sat(64'(zsum23), 30);
  end

`ifndef NO_ASSERTIONS
  // A result appears exactly the pipeline latency after an accepted item.
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, afk_pkg::PIPE_LAT))
    else $error("result without a matching accepted item");

  // The polynomial outputs never exceed one in Q30.
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    vld_c[NS] |-> (xs_c[NS][0] <= afk_pkg::ONE_Q30 && xs_c[NS][1] <= afk_pkg::ONE_Q30 &&
                   xs_c[NS][2] <= afk_pkg::ONE_Q30 && xs_c[NS][3] <= afk_pkg::ONE_Q30 &&
                   xc_c[NS][0] <= afk_pkg::ONE_Q30 && xc_c[NS][1] <= afk_pkg::ONE_Q30 &&
                   xc_c[NS][2] <= afk_pkg::ONE_Q30 && xc_c[NS][3] <= afk_pkg::ONE_Q30))
    else $error("sine or cosine magnitude above one");

  // A write to an unused index leaves every link length unchanged.
  a_cfg_ignore: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index > afk_pkg::REG_WRIST_LINK) |=>
      ($stable(base_offset) && $stable(upper_link) &&
       $stable(fore_link) && $stable(wrist_link)))
    else $error("link register changed by an unused index");
`endif

endmodule

### tb/sv/arm_fk_checker.sv
`timescale 1ns / 1ps

module arm_fk_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [17:0] base_angle,
  input  logic signed [17:0] shoulder_angle,
  input  logic signed [17:0] elbow_angle,
  input  logic signed [17:0] wrist_angle,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               done,
  input  logic signed [17:0] pos_x,
  input  logic signed [17:0] pos_y,
  input  logic signed [17:0] pos_z,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count
);

  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
  } tool_pos_t;

  typedef struct {
    longint s;
    longint c;
  } trig_t;

  logic [15:0] offset_len, upper_len, fore_len, wrist_len;
  tool_pos_t   expected_pos [$];

  assign pending_count = expected_pos.size();

  // Sine and cosine of an angle in 2^-14 rad, by way of a 32-bit phase.
  function automatic trig_t angle_trig(longint ang);
    logic [63:0] prod;
    logic [31:0] ph;
    logic [1:0]  quad;
    longint unsigned f, t, t2, a, b, s, c, k, one;
    trig_t r;
    one  = 64'd1 << 30;
    prod = 64'(ang) * 64'd10680707;
    ph   = prod[39:8];
    quad = ph[31:30];
    f    = ph[29:0];
    if (f > (one >> 1)) f = one - f;
    t  = (f * 64'd3373259426) >> 31;
    t2 = (t * t) >> 30;
    a = one - t2 / 72;
    a = one - ((t2 * a) >> 30) / 42;
    a = one - ((t2 * a) >> 30) / 20;
    a = one - ((t2 * a) >> 30) / 6;
    s = (t * a) >> 30;
    b = one - t2 / 90;
    b = one - ((t2 * b) >> 30) / 56;
    b = one - ((t2 * b) >> 30) / 30;
    b = one - ((t2 * b) >> 30) / 12;
    c = one - ((t2 * b) >> 30) / 2;
    if (ph[29:0] > (one >> 1)) begin
      k = s; s = c; c = k;
    end
    case (quad)
      2'd0: begin r.s = s;  r.c = c;  end
      2'd1: begin r.s = c;  r.c = -s; end
      2'd2: begin r.s = -s; r.c = -c; end
      default: begin r.s = -c; r.c = s; end
    endcase
    return r;
  endfunction

  function automatic logic signed [17:0] round_clamp(longint v, int sh);
    longint r;
    r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[17:0];
  endfunction

  function automatic tool_pos_t tool_position(longint q1, longint q2, longint q3, longint q4);
    trig_t j1, j2, j23, j234;
    longint reach, reach14, px, py, pz, off;
    tool_pos_t p;
    j1   = angle_trig(q1);
    j2   = angle_trig(q2);
    j23  = angle_trig(q2 + q3);
    j234 = angle_trig(q2 + q3 + q4);
    off  = offset_len;
    reach = longint'(upper_len) * j2.s + longint'(fore_len) * j23.s
          + longint'(wrist_len) * j234.s;
    reach14 = reach >>> 16;
    px = off * j1.s * 16384 - j1.c * reach14;
    py = -(off * j1.c * 16384) - j1.s * reach14;
    pz = longint'(upper_len) * j2.c + longint'(fore_len) * j23.c
       + longint'(wrist_len) * j234.c;
    p.x = round_clamp(px, 44);
    p.y = round_clamp(py, 44);
    p.z = round_clamp(pz, 30);
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [17:0] got,
                                 input logic signed [17:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Track register writes, predict accepted joint vectors, compare results.
  always @(posedge clk) begin
    tool_pos_t want;
    if (rst) begin
      offset_len   <= 16'd8520;
      upper_len    <= 16'd29229;
      fore_len     <= 16'd23658;
      wrist_len    <= 16'd9339;
      fail_count   = 0;
      result_count = 0;
      expected_pos.delete();
    end else begin
      if (done) begin
        result_count++;
        if (expected_pos.size() == 0) begin
          $display("%0t: result with no joint vector outstanding", $realtime);
          fail_count++;
        end else begin
          want = expected_pos.pop_front();
          if (pos_x !== want.x) report_mismatch("pos_x", pos_x, want.x);
          if (pos_y !== want.y) report_mismatch("pos_y", pos_y, want.y);
          if (pos_z !== want.z) report_mismatch("pos_z", pos_z, want.z);
        end
      end
      if (start && !busy)
        expected_pos.insert(expected_pos.size(),
                            tool_position(base_angle, shoulder_angle,
                                          elbow_angle, wrist_angle));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          afk_pkg::REG_BASE_OFFSET: offset_len <= cfg_data;
          afk_pkg::REG_UPPER_LINK:  upper_len  <= cfg_data;
          afk_pkg::REG_FORE_LINK:   fore_len   <= cfg_data;
          afk_pkg::REG_WRIST_LINK:  wrist_len  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/sv/arm_forward_kinematics_4dof_test.sv
`timescale 1ns / 1ps

module arm_forward_kinematics_4dof_test;

  localparam int IDLE_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [17:0] base_angle = '0, shoulder_angle = '0;
  logic signed [17:0] elbow_angle = '0, wrist_angle = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [3:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               done;
  logic signed [17:0] pos_x, pos_y, pos_z;
  int                 fail_count, pending_count, result_count;
  int                 idle_cycles = 0;
  int                 vector_count = 0;
  int                 idle_pct = 0;

  always #6 clk = ~clk;

  arm_forward_kinematics_4dof dut (.*);
  arm_fk_checker checker_i (.*);

  // Watchdog: stop when nothing has been transferred for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // One register write; waits for ready after valid is up.
  task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Present one joint vector, holding it until the transfer happens.
  // Start stays high afterward so vectors can follow back to back.
  task automatic send_joints(input logic signed [17:0] q1, q2, q3, q4);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    base_angle     <= q1;
    shoulder_angle <= q2;
    elbow_angle    <= q3;
    wrist_angle    <= q4;
    do @(posedge clk); while (busy);
    @(negedge clk);
    vector_count++;
  endtask

  // Pick an angle: mostly in the first turn, sometimes extreme or random.
  function automatic logic signed [17:0] pick_angle();
    case ($urandom_range(9, 0))
      0: return 18'sh1FFFF;
      1: return -18'sh20000;
      2, 3: return 18'($urandom);
      default: return 18'($signed($urandom_range(102944, 0)) - 51472);
    endcase
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (afk_pkg::PIPE_LAT + 4) @(negedge clk);
  endtask

  initial begin
    logic signed [17:0] corner [6];
    logic [15:0] link_set [4];
    corner = '{18'sh1FFFF, -18'sh20000, 18'sd0, 18'sd25736, -18'sd25736, 18'sd51472};
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: quadrant edges, field extremes, large sums that wrap.
    foreach (corner[i]) send_joints(corner[i], corner[(i + 1) % 6],
                                     corner[(i + 2) % 6], corner[(i + 3) % 6]);
    send_joints(18'sd0, 18'sd0, 18'sd0, 18'sd0);
    send_joints(18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF);
    send_joints(-18'sh20000, -18'sh20000, -18'sh20000, -18'sh20000);
    send_joints(18'sd12868, 18'sd12868, 18'sd12868, 18'sd12868);
    send_joints(18'sh15555, -18'sh2AAAB, 18'sh15555, -18'sh2AAAB);
    drain();

    // Link extremes: saturated reach, zero links, then an index beyond range.
    foreach (link_set[i]) link_set[i] = 16'hFFFF;
    foreach (link_set[i]) write_reg(afk_pkg::reg_idx_t'(i), link_set[i]);
    repeat (6) send_joints(pick_angle(), pick_angle(), pick_angle(), pick_angle());
    drain();
    foreach (link_set[i]) write_reg(afk_pkg::reg_idx_t'(i), 16'h0000);
    write_reg(4'd9, 16'h1234);
    repeat (6) send_joints(pick_angle(), pick_angle(), pick_angle(), pick_angle());
    drain();

    // Random phases with different link settings and sender idling.
    for (int phase = 0; phase < 5; phase++) begin
      foreach (link_set[i]) write_reg(afk_pkg::reg_idx_t'(i), 16'($urandom));
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 85;
        2: idle_pct = 22;
        3: idle_pct = 0;
        default: idle_pct = 50;
      endcase
      repeat (250) send_joints(pick_angle(), pick_angle(), pick_angle(), pick_angle());
      drain();
    end

    $display("Sent %0d joint vectors across eight link settings; %0d results checked.",
             vector_count, result_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
